/* rtl/core/mcbfp_pkg.sv */
package mcbfp_pkg;

	// Pool size and per-channel depth.
	localparam int unsigned NUM_CHANNELS  = 8;
	localparam int unsigned CHANNEL_DEPTH = 256;

	// Derived widths.
	localparam int unsigned CH_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int unsigned PTR_W   = (CHANNEL_DEPTH > 1) ? $clog2(CHANNEL_DEPTH) : 1;
	localparam int unsigned CNT_W   = $clog2(CHANNEL_DEPTH + 1);
	localparam int unsigned ADDR_W  = CH_W + PTR_W;
	localparam int unsigned MEM_DEPTH = 1 << ADDR_W;

	// Fixed field widths.
	localparam int unsigned ID_W    = 4;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned TALLY_W = 16;

	typedef enum logic [1:0] {
		CMD_CREATE = 2'd0,
		CMD_CLOSE  = 2'd1,
		CMD_WRITE  = 2'd2,
		CMD_READ   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_BAD    = 2'd1,
		ST_NOROOM = 2'd2,
		ST_NOFREE = 2'd3
	} status_t;

	// Decision of the channel table for one accepted item.
	typedef struct packed {
		status_t             status;
		logic [ID_W-1:0]     new_channel;
		logic                moved;
		logic                wr_en;
		logic                rd_en;
		logic [ADDR_W-1:0]   addr;
	} tbl_resp_t;

	// Advance a ring pointer, wrapping at the channel depth.
	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(CHANNEL_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + PTR_W'(1);
		end
		return r;
	endfunction

endpackage

/* rtl/core/mcbfp_in_if.sv */
interface mcbfp_in_if;
	logic                               valid;
	logic                               ready;
	mcbfp_pkg::cmd_t                    cmd;
	logic [mcbfp_pkg::ID_W-1:0]         pipe_id;
	logic [mcbfp_pkg::BYTE_W-1:0]       data_byte;
	logic                               last_of_call;

	modport source (output valid, cmd, pipe_id, data_byte, last_of_call, input ready);
	modport sink (input valid, cmd, pipe_id, data_byte, last_of_call, output ready);
endinterface

/* rtl/core/mcbfp_out_if.sv */
interface mcbfp_out_if;
	logic                               valid;
	logic                               ready;
	mcbfp_pkg::status_t                 status;
	logic [mcbfp_pkg::ID_W-1:0]         new_channel;
	logic [mcbfp_pkg::BYTE_W-1:0]       read_data;
	logic [mcbfp_pkg::TALLY_W-1:0]      moved_in_call;

	modport source (output valid, status, new_channel, read_data, moved_in_call, input ready);
	modport sink (input valid, status, new_channel, read_data, moved_in_call, output ready);
endinterface

/* rtl/core/mcbfp_ram.sv */
module mcbfp_ram #(
	parameter int unsigned WIDTH  = 8,
	parameter int unsigned DEPTH  = 2048,
	parameter int unsigned ADDR_W = 11
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// One write port; read data is registered and holds until the next read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* rtl/core/mcbfp_chan_tbl.sv */
module mcbfp_chan_tbl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  mcbfp_pkg::cmd_t               cmd,
	input  logic [mcbfp_pkg::ID_W-1:0]    pipe_id,
	output mcbfp_pkg::tbl_resp_t          resp
);

	localparam int unsigned NCH = mcbfp_pkg::NUM_CHANNELS;
	localparam int unsigned CHW = mcbfp_pkg::CH_W;
	localparam int unsigned PW  = mcbfp_pkg::PTR_W;
	localparam int unsigned CW  = mcbfp_pkg::CNT_W;

	logic [NCH-1:0] in_use_q;
	logic [PW-1:0]  head_q [NCH];
	logic [PW-1:0]  tail_q [NCH];
	logic [CW-1:0]  fill_q [NCH];

	logic           id_ok;
	logic [CHW-1:0] idx;
	logic           sel_used;
	logic           found;
	logic [CHW-1:0] free_idx;
	logic           full;
	logic           empty;

	// Range check and channel select for close, write and read.
	assign id_ok    = ({1'b0, pipe_id} < (mcbfp_pkg::ID_W + 1)'(NCH));
	assign idx      = pipe_id[CHW-1:0];
	assign sel_used = id_ok && in_use_q[idx];
	assign full     = (fill_q[idx] == CW'(mcbfp_pkg::CHANNEL_DEPTH));
	assign empty    = (fill_q[idx] == '0);

	// Lowest-numbered free channel.
	always_comb begin
		found    = 1'b0;
		free_idx = '0;
		for (int c = NCH - 1; c >= 0; c--) begin
			if (!in_use_q[c]) begin
				found    = 1'b1;
				free_idx = CHW'(c);
			end
		end
	end

	// Command decode.
	always_comb begin
		resp             = '0;
		resp.status      = mcbfp_pkg::ST_OK;
		unique case (cmd)
			mcbfp_pkg::CMD_CREATE: begin
				if (found) begin
					resp.new_channel = mcbfp_pkg::ID_W'(free_idx);
				end else begin
					resp.status = mcbfp_pkg::ST_NOFREE;
				end
			end
			mcbfp_pkg::CMD_CLOSE: begin
				resp.status = mcbfp_pkg::ST_OK;
			end
			mcbfp_pkg::CMD_WRITE: begin
				resp.addr = {idx, tail_q[idx]};
				if (!sel_used) begin
					resp.status = mcbfp_pkg::ST_BAD;
				end else if (full) begin
					resp.status = mcbfp_pkg::ST_NOROOM;
				end else begin
					resp.moved = 1'b1;
					resp.wr_en = 1'b1;
				end
			end
			mcbfp_pkg::CMD_READ: begin
				resp.addr = {idx, head_q[idx]};
				if (!sel_used) begin
					resp.status = mcbfp_pkg::ST_BAD;
				end else if (empty) begin
					resp.status = mcbfp_pkg::ST_NOROOM;
				end else begin
					resp.moved = 1'b1;
					resp.rd_en = 1'b1;
				end
			end
			default: begin
				resp.status = mcbfp_pkg::ST_OK;
			end
		endcase
	end

	// Per-channel state update on each accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= '0;
			for (int c = 0; c < NCH; c++) begin
				head_q[c] <= '0;
				tail_q[c] <= '0;
				fill_q[c] <= '0;
			end
		end else if (accept) begin
			case (cmd)
				mcbfp_pkg::CMD_CREATE: begin
					if (found) begin
						in_use_q[free_idx] <= 1'b1;
						head_q[free_idx]   <= '0;
						tail_q[free_idx]   <= '0;
						fill_q[free_idx]   <= '0;
					end
				end
				mcbfp_pkg::CMD_CLOSE: begin
					if (id_ok) begin
						in_use_q[idx] <= 1'b0;
						head_q[idx]   <= '0;
						tail_q[idx]   <= '0;
						fill_q[idx]   <= '0;
					end
				end
				mcbfp_pkg::CMD_WRITE: begin
					if (resp.wr_en) begin
						tail_q[idx] <= mcbfp_pkg::ptr_next(tail_q[idx]);
						fill_q[idx] <= fill_q[idx] + CW'(1);
					end
				end
				default: begin
					if (resp.rd_en) begin
						head_q[idx] <= mcbfp_pkg::ptr_next(head_q[idx]);
						fill_q[idx] <= fill_q[idx] - CW'(1);
					end
				end
			endcase
		end
	end

endmodule

/* rtl/core/multi_channel_byte_fifo_pool_unit.sv */
// Pool of independent circular byte FIFOs sharing one byte store. Each
// accepted item (create, close, write byte or read byte) yields exactly one
// result in the cycle after its transfer, and a new item can be taken every
// clock as long as the result register is free or being emptied in the
// same cycle. Read data comes from the registered read port of the
// shared byte store; channel pointers, fill counts and the in-use flags sit in
// a small table in flip-flops that reset clears at once, so no clearing pass
// is needed after reset. Unwritten bytes in the store read as undefined.
module multi_channel_byte_fifo_pool_unit (
	input logic          clk,
	input logic          arst_n,
	mcbfp_in_if.sink     req,
	mcbfp_out_if.source  rsp
);

	localparam int unsigned TW = mcbfp_pkg::TALLY_W;

	mcbfp_pkg::tbl_resp_t           tbl;
	logic                           accept;
	logic [mcbfp_pkg::BYTE_W-1:0]   mem_rd;

	logic                           valid_q;
	mcbfp_pkg::status_t             status_q;
	logic [mcbfp_pkg::ID_W-1:0]     chan_q;
	logic [TW-1:0]                  moved_q;
	logic                           rd_ok_q;
	logic [TW-1:0]                  tally_q;
	logic [TW-1:0]                  tally_inc;

	// Take an item whenever the result register is free or being drained.
	assign req.ready = !valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	mcbfp_chan_tbl u_tbl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.cmd     (req.cmd),
		.pipe_id (req.pipe_id),
		.resp    (tbl)
	);

	mcbfp_ram #(
		.WIDTH  (mcbfp_pkg::BYTE_W),
		.DEPTH  (mcbfp_pkg::MEM_DEPTH),
		.ADDR_W (mcbfp_pkg::ADDR_W)
	) u_store (
		.clk     (clk),
		.wr_en   (accept && tbl.wr_en),
		.wr_addr (tbl.addr),
		.wr_data (req.data_byte),
		.rd_en   (accept && tbl.rd_en),
		.rd_addr (tbl.addr),
		.rd_data (mem_rd)
	);

	// Saturating count of bytes moved in the current call.
	always_comb begin
		tally_inc = tally_q;
		if (tbl.moved && (tally_q != {TW{1'b1}})) begin
			tally_inc = tally_q + TW'(1);
		end
	end

	// Call tally and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tally_q <= '0;
		end else begin
			if (accept) begin
				valid_q <= 1'b1;
			end else if (rsp.ready) begin
				valid_q <= 1'b0;
			end
			if (accept) begin
				if ((req.cmd == mcbfp_pkg::CMD_CREATE) || (req.cmd == mcbfp_pkg::CMD_CLOSE)
						|| req.last_of_call) begin
					tally_q <= '0;
				end else begin
					tally_q <= tally_inc;
				end
			end
		end
	end

	// Result payload; read data comes straight from the store's read register.
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= tbl.status;
			chan_q   <= tbl.new_channel;
			rd_ok_q  <= tbl.rd_en;
			if ((req.cmd == mcbfp_pkg::CMD_CREATE) || (req.cmd == mcbfp_pkg::CMD_CLOSE)) begin
				moved_q <= '0;
			end else begin
				moved_q <= tally_inc;
			end
		end
	end

	assign rsp.valid         = valid_q;
	assign rsp.status        = status_q;
	assign rsp.new_channel   = chan_q;
	assign rsp.read_data     = rd_ok_q ? mem_rd : '0;
	assign rsp.moved_in_call = moved_q;

endmodule

/* dv/tb.sv */
module tb;
	import mcbfp_pkg::*;

	localparam int CYCLE_LIMIT    = 2_000_000;
	localparam int RX_HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES   = 8;
	localparam int SCRIPT_ROWS    = 24;

	// One request to the pool and the reply it earns.
	typedef struct packed {
		cmd_t              cmd;
		logic [ID_W-1:0]   pipe_id;
		logic [BYTE_W-1:0] data_byte;
		logic              last_of_call;
	} pool_req_t;

	typedef struct packed {
		status_t            status;
		logic [ID_W-1:0]    new_channel;
		logic [BYTE_W-1:0]  read_data;
		logic [TALLY_W-1:0] moved_in_call;
	} pool_rsp_t;

	// A step of the opening script. A step is issued reps times with the byte
	// counting up; with alternate set, each repeat is a write then a read on the
	// same channel. Steps with typed set carry the reply that they must get.
	typedef struct packed {
		cmd_t               cmd;
		logic [ID_W-1:0]    id;
		logic [BYTE_W-1:0]  data;
		logic               last;
		logic [16:0]        reps;
		logic               alternate;
		logic               typed;
		status_t            st;
		logic [ID_W-1:0]    chan;
		logic [BYTE_W-1:0]  rdata;
		logic [TALLY_W-1:0] moved;
	} script_step_t;

	script_step_t opening_script [SCRIPT_ROWS] = '{
		'{CMD_READ,   4'd0,  8'h00, 1'b1, 17'd1,     1'b0, 1'b1, ST_BAD,    4'd0, 8'h00, 16'd0},
		'{CMD_WRITE,  4'd15, 8'hA5, 1'b1, 17'd1,     1'b0, 1'b1, ST_BAD,    4'd0, 8'h00, 16'd0},
		'{CMD_CLOSE,  4'd12, 8'h00, 1'b0, 17'd1,     1'b0, 1'b1, ST_OK,     4'd0, 8'h00, 16'd0},
		'{CMD_CREATE, 4'd0,  8'h00, 1'b0, 17'd1,     1'b0, 1'b1, ST_OK,     4'd0, 8'h00, 16'd0},
		'{CMD_CREATE, 4'd0,  8'h00, 1'b0, 17'd1,     1'b0, 1'b1, ST_OK,     4'd1, 8'h00, 16'd0},
		'{CMD_READ,   4'd0,  8'h00, 1'b1, 17'd1,     1'b0, 1'b1, ST_NOROOM, 4'd0, 8'h00, 16'd0},
		'{CMD_WRITE,  4'd0,  8'h00, 1'b0, 17'd1,     1'b0, 1'b0, ST_OK,     4'd0, 8'h00, 16'd0},
		'{CMD_WRITE,  4'd0,  8'hFF, 1'b1, 17'd1,     1'b0, 1'b0, ST_OK,     4'd0, 8'h00, 16'd0},
		'{CMD_READ,   4'd0,  8'h00, 1'b0, 17'd1,     1'b0, 1'b0, ST_OK,     4'd0, 8'h00, 16'd0},
		'{CMD_READ,   4'd0,  8'h00, 1'b1, 17'd1,     1'b0, 1'b0, ST_OK,     4'd0, 8'h00, 16'd0},
		'{CMD_WRITE,  4'd1,  8'h10, 1'b0, 17'd256,   1'b0, 1'b0, ST_OK,     4'd0, 8'h00, 16'd0},
		'{CMD_WRITE,  4'd1,  8'h77, 1'b1, 17'd1,     1'b0, 1'b1, ST_NOROOM, 4'd0, 8'h00, 16'd256},
		'{CMD_READ,   4'd1,  8'h00, 1'b0, 17'd256,   1'b0, 1'b0, ST_OK,     4'd0, 8'h00, 16'd0},
		'{CMD_READ,   4'd1,  8'h00, 1'b1, 17'd1,     1'b0, 1'b1, ST_NOROOM, 4'd0, 8'h00, 16'd256},
		'{CMD_CREATE, 4'd0,  8'h00, 1'b0, 17'd6,     1'b0, 1'b0, ST_OK,     4'd0, 8'h00, 16'd0},
		'{CMD_CREATE, 4'd9,  8'h00, 1'b0, 17'd1,     1'b0, 1'b1, ST_NOFREE, 4'd0, 8'h00, 16'd0},
		'{CMD_CLOSE,  4'd3,  8'h00, 1'b0, 17'd1,     1'b0, 1'b1, ST_OK,     4'd0, 8'h00, 16'd0},
		'{CMD_CREATE, 4'd0,  8'h00, 1'b0, 17'd1,     1'b0, 1'b1, ST_OK,     4'd3, 8'h00, 16'd0},
		'{CMD_WRITE,  4'd2,  8'h00, 1'b0, 17'd4,     1'b1, 1'b0, ST_OK,     4'd0, 8'h00, 16'd0},
		'{CMD_WRITE,  4'd2,  8'h5A, 1'b1, 17'd1,     1'b0, 1'b1, ST_OK,     4'd0, 8'h00, 16'd9},
		'{CMD_READ,   4'd2,  8'h00, 1'b1, 17'd1,     1'b0, 1'b1, ST_OK,     4'd0, 8'h5A, 16'd1},
		'{CMD_CLOSE,  4'd0,  8'h00, 1'b1, 17'd1,     1'b0, 1'b1, ST_OK,     4'd0, 8'h00, 16'd0},
		'{CMD_WRITE,  4'd0,  8'h3C, 1'b1, 17'd1,     1'b0, 1'b1, ST_BAD,    4'd0, 8'h00, 16'd0},
		'{CMD_CLOSE,  4'd1,  8'h00, 1'b0, 17'd1,     1'b0, 1'b0, ST_OK,     4'd0, 8'h00, 16'd0}
	};

	logic clk = 1'b0;
	logic arst_n;

	mcbfp_in_if  req_if ();
	mcbfp_out_if rsp_if ();

	multi_channel_byte_fifo_pool_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	always #2 clk = ~clk;

	// Shadow copy of the pool.
	logic               chan_open   [NUM_CHANNELS];
	logic [PTR_W-1:0]   rd_ptr      [NUM_CHANNELS];
	logic [PTR_W-1:0]   wr_ptr      [NUM_CHANNELS];
	logic [CNT_W-1:0]   occupancy   [NUM_CHANNELS];
	logic [BYTE_W-1:0]  ring_bytes  [NUM_CHANNELS][CHANNEL_DEPTH];
	logic [TALLY_W-1:0] call_tally;

	pool_rsp_t pending_replies [$];
	int        failures;
	int        cycle_count;
	int        random_items;
	int        tx_idle_pct;
	int        rx_idle_pct;
	int        hold_requests;

	function automatic logic [PTR_W-1:0] ring_advance(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(CHANNEL_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	function automatic void bump_tally();
		if (call_tally != '1) begin
			call_tally = call_tally + 1'b1;
		end
	endfunction

	// Apply one accepted request to the shadow pool and return its reply.
	function automatic pool_rsp_t predict_pool_reply(input pool_req_t item);
		pool_rsp_t r;
		int id;
		r = '0;
		r.status = ST_OK;
		id = int'(item.pipe_id);
		case (item.cmd)
		CMD_CREATE: begin
			r.status = ST_NOFREE;
			for (int c = 0; c < int'(NUM_CHANNELS); c++) begin
				if (!chan_open[c]) begin
					chan_open[c] = 1'b1;
					rd_ptr[c] = '0;
					wr_ptr[c] = '0;
					occupancy[c] = '0;
					r.status = ST_OK;
					r.new_channel = ID_W'(c);
					break;
				end
			end
			call_tally = '0;
		end
		CMD_CLOSE: begin
			if (id < int'(NUM_CHANNELS)) begin
				chan_open[id] = 1'b0;
				rd_ptr[id] = '0;
				wr_ptr[id] = '0;
				occupancy[id] = '0;
			end
			call_tally = '0;
		end
		default: begin
			if (id >= int'(NUM_CHANNELS) || !chan_open[id]) begin
				r.status = ST_BAD;
			end else if (item.cmd == CMD_WRITE) begin
				if (occupancy[id] == CNT_W'(CHANNEL_DEPTH)) begin
					r.status = ST_NOROOM;
				end else begin
					ring_bytes[id][wr_ptr[id]] = item.data_byte;
					wr_ptr[id] = ring_advance(wr_ptr[id]);
					occupancy[id] = occupancy[id] + 1'b1;
					bump_tally();
				end
			end else begin
				if (occupancy[id] == '0) begin
					r.status = ST_NOROOM;
				end else begin
					r.read_data = ring_bytes[id][rd_ptr[id]];
					rd_ptr[id] = ring_advance(rd_ptr[id]);
					occupancy[id] = occupancy[id] - 1'b1;
					bump_tally();
				end
			end
			r.moved_in_call = call_tally;
			if (item.last_of_call) begin
				call_tally = '0;
			end
		end
		endcase
		return r;
	endfunction

	// Random open channel, or -1 when the pool is empty.
	function automatic int pick_open_channel();
		int open_ids [$];
		for (int c = 0; c < int'(NUM_CHANNELS); c++) begin
			if (chan_open[c]) begin
				open_ids.push_back(c);
			end
		end
		if (open_ids.size() == 0) begin
			return -1;
		end
		return open_ids[$urandom_range(open_ids.size() - 1)];
	endfunction

	// Offer one request after a random gap and wait for its transfer. The reply
	// is predicted at the transfer so the shadow pool follows the block's order.
	task automatic offer_request(input pool_req_t item, input logic typed,
		input pool_rsp_t typed_rsp);
		pool_rsp_t predicted;
		while ($urandom_range(99) < tx_idle_pct) begin
			req_if.valid <= 1'b0;
			@(negedge clk);
		end
		req_if.valid        <= 1'b1;
		req_if.cmd          <= item.cmd;
		req_if.pipe_id      <= item.pipe_id;
		req_if.data_byte    <= item.data_byte;
		req_if.last_of_call <= item.last_of_call;
		@(posedge clk);
		while (!req_if.ready) begin
			@(posedge clk);
		end
		predicted = predict_pool_reply(item);
		pending_replies.push_back(typed ? typed_rsp : predicted);
		@(negedge clk);
	endtask

	// One software-level action: mostly whole read or write calls on open
	// channels, with creates, closes, stray requests and broken call markers.
	task automatic random_action();
		pool_req_t it;
		int roll;
		int id;
		int len;
		logic is_write;
		roll = $urandom_range(99);
		it.pipe_id = ID_W'($urandom_range(15));
		it.data_byte = BYTE_W'($urandom);
		it.last_of_call = 1'($urandom);
		if (roll < 8) begin
			it.cmd = CMD_CREATE;
			offer_request(it, 1'b0, '0);
			random_items++;
		end else if (roll < 14) begin
			it.cmd = CMD_CLOSE;
			id = ($urandom_range(9) < 7) ? pick_open_channel() : -1;
			if (id >= 0) begin
				it.pipe_id = ID_W'(id);
			end
			offer_request(it, 1'b0, '0);
			random_items++;
		end else if (roll < 19) begin
			it.cmd = cmd_t'($urandom_range(3));
			offer_request(it, 1'b0, '0);
			random_items++;
		end else begin
			is_write = ($urandom_range(99) < 55);
			id = ($urandom_range(9) != 0) ? pick_open_channel() : -1;
			if (id < 0) begin
				id = $urandom_range(15);
			end
			len = ($urandom_range(39) == 0) ? $urandom_range(40, 20) : $urandom_range(8, 1);
			for (int k = 0; k < len; k++) begin
				it.cmd = is_write ? CMD_WRITE : CMD_READ;
				it.pipe_id = ID_W'(id);
				it.data_byte = BYTE_W'($urandom);
				it.last_of_call = (k == len - 1);
				// Now and then the end-of-call marker is lost or comes early.
				if ($urandom_range(49) == 0) begin
					it.last_of_call = ~it.last_of_call;
				end
				offer_request(it, 1'b0, '0);
				random_items++;
			end
		end
	endtask

	// Reply side: random stalls, plus one long hold-off on request.
	initial begin
		int hold_left;
		int holds_served;
		hold_left = 0;
		holds_served = 0;
		rsp_if.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (holds_served != hold_requests) begin
				holds_served = hold_requests;
				hold_left = RX_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// Check every reply transfer against the oldest prediction.
	always @(posedge clk) begin
		pool_rsp_t seen;
		pool_rsp_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			seen.status = rsp_if.status;
			seen.new_channel = rsp_if.new_channel;
			seen.read_data = rsp_if.read_data;
			seen.moved_in_call = rsp_if.moved_in_call;
			if (pending_replies.size() == 0) begin
				failures++;
				if (failures <= 10) begin
					$display("unexpected reply: status %0d chan %0d data %02h moved %0d",
						seen.status, seen.new_channel, seen.read_data, seen.moved_in_call);
				end
			end else begin
				want = pending_replies.pop_front();
				if (seen.status !== want.status || seen.new_channel !== want.new_channel ||
					seen.read_data !== want.read_data ||
					seen.moved_in_call !== want.moved_in_call) begin
					failures++;
					if (failures <= 10) begin
						$display("reply mismatch at cycle %0d: expected status %0d chan %0d data %02h moved %0d, got status %0d chan %0d data %02h moved %0d",
							cycle_count, want.status, want.new_channel, want.read_data,
							want.moved_in_call, seen.status, seen.new_channel, seen.read_data,
							seen.moved_in_call);
					end
				end
			end
		end
	end

	// Watchdog.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("** multi_channel_byte_fifo_pool_unit: FAILED **");
		$finish;
	end

	// Reset, opening script, then three phases of random traffic.
	initial begin
		pool_req_t it;
		pool_rsp_t typed_rsp;
		failures = 0;
		random_items = 0;
		hold_requests = 0;
		tx_idle_pct = 12;
		rx_idle_pct = 59;
		call_tally = '0;
		for (int c = 0; c < int'(NUM_CHANNELS); c++) begin
			chan_open[c] = 1'b0;
			rd_ptr[c] = '0;
			wr_ptr[c] = '0;
			occupancy[c] = '0;
		end
		arst_n = 1'b0;
		req_if.valid        <= 1'b0;
		req_if.cmd          <= CMD_CREATE;
		req_if.pipe_id      <= '0;
		req_if.data_byte    <= '0;
		req_if.last_of_call <= 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (opening_script[i]) begin
			for (int k = 0; k < int'(opening_script[i].reps); k++) begin
				it.cmd = opening_script[i].cmd;
				it.pipe_id = opening_script[i].id;
				it.data_byte = opening_script[i].data + BYTE_W'(k);
				it.last_of_call = opening_script[i].last;
				typed_rsp.status = opening_script[i].st;
				typed_rsp.new_channel = opening_script[i].chan;
				typed_rsp.read_data = opening_script[i].rdata;
				typed_rsp.moved_in_call = opening_script[i].moved;
				if (opening_script[i].alternate) begin
					it.cmd = CMD_WRITE;
					offer_request(it, 1'b0, '0);
					it.cmd = CMD_READ;
					offer_request(it, 1'b0, '0);
				end else begin
					offer_request(it, opening_script[i].typed, typed_rsp);
				end
			end
		end

		while (random_items < 60) begin
			random_action();
		end
		tx_idle_pct = 59;
		rx_idle_pct = 12;
		while (random_items < 110) begin
			random_action();
		end
		// No idling from here; one long reply hold-off backs the block up.
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_requests++;
		while (random_items < 155) begin
			random_action();
		end
		req_if.valid <= 1'b0;

		while (pending_replies.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		failures += pending_replies.size();
		if (failures == 0) begin
			$display("** multi_channel_byte_fifo_pool_unit: PASSED **");
		end else begin
			$display("** multi_channel_byte_fifo_pool_unit: FAILED **");
		end
		$finish;
	end

endmodule

/* files.f */
rtl/core/mcbfp_pkg.sv
rtl/core/mcbfp_in_if.sv
rtl/core/mcbfp_out_if.sv
rtl/core/mcbfp_ram.sv
rtl/core/mcbfp_chan_tbl.sv
rtl/core/multi_channel_byte_fifo_pool_unit.sv
dv/tb.sv
